### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Q table update engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, masked while reset is active.
`define QT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define QT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/qtue_pkg.sv
// ----------------------------------------------------------------------------
// qtue_pkg
// Field widths, register codes, controller/datapath interface types and
// saturating accumulator helpers for the Q table update engine.
// ----------------------------------------------------------------------------
package qtue_pkg;

    // Port field widths
    localparam int STATE_IN_W = 8;
    localparam int ACT_IN_W   = 2;
    localparam int REWARD_W   = 32;
    localparam int OUT_Q_W    = 32;
    localparam int OUT_ACT_W  = 2;

    // Fixed point: unsigned Q0.16 coefficients, 64-bit accumulator
    localparam int FRAC_W = 16;
    localparam int ACC_W  = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = CFG_IDX_W'(1);

    localparam logic [FRAC_W-1:0] LEARN_RATE_RST = FRAC_W'(6554);
    localparam logic [FRAC_W-1:0] DISCOUNT_RST   = FRAC_W'(58982);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic clr_wr;     // write zero at the clear pointer, advance it
        logic load;       // capture a transfer from the input channel
        logic rd_row;     // read the next entry of the next-state row
        logic rd_q;       // read the entry being updated
        logic mul_gamma;  // capture old Q, multiply row max by discount
        logic add_exp;    // expected = reward + gamma*max
        logic sub_diff;   // diff = expected - Q
        logic mul_alpha;  // multiply diff by learn rate
        logic upd;        // new Q = Q + alpha*diff, clamped to Q range
        logic commit;     // write back and load the result register
    } t_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic clr_last;   // clear pointer is at the last entry
        logic row_last;   // row pointer is at the last action
    } t_status;

    typedef struct packed {
        logic                    ovf;
        logic signed [ACC_W-1:0] val;
    } t_sat;

    // Saturating add in the accumulator width
    function automatic t_sat sat_add(input logic signed [ACC_W-1:0] a,
                                     input logic signed [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        t_sat           res;
        s       = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        res.ovf = s[ACC_W] ^ s[ACC_W-1];
        res.val = res.ovf ? (s[ACC_W] ? ACC_MIN : ACC_MAX) : s[ACC_W-1:0];
        return res;
    endfunction

    // Saturating subtract in the accumulator width
    function automatic t_sat sat_sub(input logic signed [ACC_W-1:0] a,
                                     input logic signed [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        t_sat           res;
        s       = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        res.ovf = s[ACC_W] ^ s[ACC_W-1];
        res.val = res.ovf ? (s[ACC_W] ? ACC_MIN : ACC_MAX) : s[ACC_W-1:0];
        return res;
    endfunction

endpackage

### design/qtue_datapath.sv
// ----------------------------------------------------------------------------
// qtue_datapath
// Q table memory, configuration registers, row max search, shared fraction
// multiplier, saturating accumulator and result register.
// ----------------------------------------------------------------------------
module qtue_datapath import qtue_pkg::*; #(
    parameter int NUM_STATES  = 256,
    parameter int NUM_ACTIONS = 4,
    parameter int Q_WIDTH     = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic [STATE_IN_W-1:0]        i_cur_state,
    input  logic [ACT_IN_W-1:0]          i_taken_action,
    input  logic signed [REWARD_W-1:0]   i_reward_value,
    input  logic [STATE_IN_W-1:0]        i_next_state,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    output logic signed [OUT_Q_W-1:0]    o_updated_q,
    output logic signed [OUT_Q_W-1:0]    o_next_max_q,
    output logic [OUT_ACT_W-1:0]         o_greedy_action,
    output logic                         o_saturated
);

    localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int SW     = $clog2(NUM_STATES);
    localparam int AW     = $clog2(NUM_ACTIONS);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MUL_W  = ACC_W + FRAC_W + 1;

    // Bounds of the Q range in the widened sum
    localparam int HI_W = ACC_W + 2 - Q_WIDTH;

    typedef logic [SW-1:0] t_smod_tbl [2**STATE_IN_W];
    typedef logic [AW-1:0] t_amod_tbl [2**ACT_IN_W];

    // Wrap an input state code into the table's row range
    function automatic t_smod_tbl build_smod();
        t_smod_tbl tbl;
        int        m;
        m = 0;
        for (int i = 0; i < 2**STATE_IN_W; i++) begin
            tbl[i] = SW'(m);
            m      = (m == NUM_STATES - 1) ? 0 : m + 1;
        end
        return tbl;
    endfunction

    // Wrap an input action code into the column range
    function automatic t_amod_tbl build_amod();
        t_amod_tbl tbl;
        int        m;
        m = 0;
        for (int i = 0; i < 2**ACT_IN_W; i++) begin
            tbl[i] = AW'(m);
            m      = (m == NUM_ACTIONS - 1) ? 0 : m + 1;
        end
        return tbl;
    endfunction

    localparam t_smod_tbl SMOD = build_smod();
    localparam t_amod_tbl AMOD = build_amod();

    // Configuration
    logic [FRAC_W-1:0] r_alpha;
    logic [FRAC_W-1:0] r_gamma;

    // Transfer context
    logic [ADDR_W-1:0]          r_cur_addr;
    logic [ADDR_W-1:0]          r_ns_base;
    logic signed [REWARD_W-1:0] r_reward;
    logic [AW-1:0]              r_idx;
    logic [ADDR_W-1:0]          r_clr_addr;

    // Memory and read pipeline
    logic signed [Q_WIDTH-1:0]  r_mem [DEPTH];
    logic signed [Q_WIDTH-1:0]  r_rd_data;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic signed [Q_WIDTH-1:0]  wr_data;
    logic                       r_cmp_vld;
    logic [AW-1:0]              r_cmp_idx;

    // Arithmetic
    logic signed [Q_WIDTH-1:0]  r_best;
    logic [AW-1:0]              r_best_idx;
    logic signed [Q_WIDTH-1:0]  r_q;
    logic signed [ACC_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]    r_exp;
    logic signed [ACC_W-1:0]    r_diff;
    logic signed [Q_WIDTH-1:0]  r_upd;
    logic                       r_sat;

    // Result register
    logic signed [OUT_Q_W-1:0]  r_o_upd;
    logic signed [OUT_Q_W-1:0]  r_o_max;
    logic [OUT_ACT_W-1:0]       r_o_greedy;
    logic                       r_o_sat;

    logic [SW-1:0]              smod;
    logic [AW-1:0]              amod;
    logic [SW-1:0]              nsmod;
    logic signed [ACC_W-1:0]    best_ext;
    logic signed [ACC_W-1:0]    q_ext;
    logic signed [ACC_W-1:0]    upd_ext;
    logic signed [ACC_W-1:0]    reward_ext;
    logic signed [ACC_W-1:0]    mul_x;
    logic [FRAC_W-1:0]          mul_f;
    logic signed [MUL_W-1:0]    mul_p;
    t_sat                       exp_sum;
    t_sat                       diff_sum;
    logic signed [ACC_W:0]      upd_sum;
    logic [HI_W-1:0]            upd_hi;
    logic                       upd_ovf;
    logic [AW+OUT_ACT_W-1:0]    idx_ext;

    // Register writes; drop writes to unmapped indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= LEARN_RATE_RST;
            r_gamma <= DISCOUNT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_LEARN_RATE: begin
                    r_alpha <= i_cfg_wdata;
                end
                REG_DISCOUNT: begin
                    r_gamma <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Clear pointer sweeps the table once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    assign o_status.clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_status.row_last = (r_idx == AW'(NUM_ACTIONS - 1));

    // Capture the transfer and walk the next-state row
    assign smod  = SMOD[i_cur_state];
    assign amod  = AMOD[i_taken_action];
    assign nsmod = SMOD[i_next_state];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_addr <= ADDR_W'(32'(smod) * NUM_ACTIONS + 32'(amod));
            r_ns_base  <= ADDR_W'(32'(nsmod) * NUM_ACTIONS);
            r_reward   <= i_reward_value;
            r_idx      <= '0;
        end else if (i_cmd.rd_row) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // Memory ports: one write, one registered read
    assign rd_addr = i_cmd.rd_q ? r_cur_addr : r_ns_base + ADDR_W'(r_idx);
    assign wr_en   = i_cmd.clr_wr | i_cmd.commit;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : r_cur_addr;
    assign wr_data = i_cmd.clr_wr ? '0 : r_upd;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
    end

    // Track which row entry arrives on the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
    end

    // Running max; strict compare keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && ((r_cmp_idx == '0) || (r_rd_data > r_best))) begin
            r_best     <= r_rd_data;
            r_best_idx <= r_cmp_idx;
        end
    end

    // Shared fraction multiplier: floor(x * f / 2^16)
    assign best_ext = ACC_W'(r_best);
    assign mul_x    = i_cmd.mul_alpha ? r_diff : best_ext;
    assign mul_f    = i_cmd.mul_alpha ? r_alpha : r_gamma;
    assign mul_p    = mul_x * $signed({1'b0, mul_f});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_gamma || i_cmd.mul_alpha) begin
            r_prod <= mul_p[ACC_W+FRAC_W-1:FRAC_W];
        end
        if (i_cmd.mul_gamma) begin
            r_q <= r_rd_data;
        end
    end

    // Saturating accumulator steps
    assign reward_ext = ACC_W'(r_reward);
    assign q_ext      = ACC_W'(r_q);
    assign exp_sum    = sat_add(reward_ext, r_prod);
    assign diff_sum   = sat_sub(r_exp, q_ext);

    // Final add clamps to the Q range: the top bits must all match the sign
    assign upd_sum = (ACC_W+1)'(r_q) + (ACC_W+1)'(r_prod);
    assign upd_hi  = upd_sum[ACC_W:Q_WIDTH-1];
    assign upd_ovf = !((&upd_hi) || !(|upd_hi));

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_exp) begin
            r_exp <= exp_sum.val;
            r_sat <= exp_sum.ovf;
        end
        if (i_cmd.sub_diff) begin
            r_diff <= diff_sum.val;
            r_sat  <= r_sat | diff_sum.ovf;
        end
        if (i_cmd.upd) begin
            r_sat <= r_sat | upd_ovf;
            if (upd_ovf) begin
                r_upd <= upd_sum[ACC_W] ? {1'b1, {(Q_WIDTH-1){1'b0}}}
                                        : {1'b0, {(Q_WIDTH-1){1'b1}}};
            end else begin
                r_upd <= upd_sum[Q_WIDTH-1:0];
            end
        end
    end

    // Result register, loaded with the write-back
    assign upd_ext = ACC_W'(r_upd);
    assign idx_ext = (AW+OUT_ACT_W)'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_upd    <= upd_ext[OUT_Q_W-1:0];
            r_o_max    <= best_ext[OUT_Q_W-1:0];
            r_o_greedy <= idx_ext[OUT_ACT_W-1:0];
            r_o_sat    <= r_sat;
        end
    end

    assign o_updated_q     = r_o_upd;
    assign o_next_max_q    = r_o_max;
    assign o_greedy_action = r_o_greedy;
    assign o_saturated     = r_o_sat;

endmodule

### design/qtue_ctrl.sv
// ----------------------------------------------------------------------------
// qtue_ctrl
// Sequencer for the update engine: table clear after reset, row read, two
// multiply steps, write-back, and the handshakes of both channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qtue_ctrl import qtue_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ROW   = 4'd2;
    localparam logic [3:0] S_QRD   = 4'd3;
    localparam logic [3:0] S_LAST  = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_SUB   = 4'd6;
    localparam logic [3:0] S_MULA  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_WRITE = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.rd_row = 1'b1;
                if (i_status.row_last) begin
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                o_cmd.rd_q = 1'b1;
                n_state    = S_LAST;
            end
            S_LAST: begin
                o_cmd.mul_gamma = 1'b1;
                n_state         = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_exp = 1'b1;
                n_state       = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub_diff = 1'b1;
                n_state        = S_MULA;
            end
            S_MULA: begin
                o_cmd.mul_alpha = 1'b1;
                n_state         = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                // hold until the result register is free
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Result valid: set on write-back, drop on transfer
    always_comb begin
        priority if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `QT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == S_CLEAR), "no clear after reset")
    `QT_ASSERT(a_accept_reads_row, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_ROW), "transfer did not start row read")
    `QT_ASSERT(a_commit_free, i_clk, i_rst_n, o_cmd.commit |-> (!r_out_valid || i_out_ready), "result overwritten before transfer")
    `QT_ASSERT(a_commit_shows, i_clk, i_rst_n, o_cmd.commit |=> o_out_valid, "write-back did not raise result valid")

endmodule

### design/q_table_update_engine.sv
// ----------------------------------------------------------------------------
// q_table_update_engine
// Tabular Q-learning update: max over the next state's row, then a
// saturating Q16.16 update of Q[s][a] written back to the table.
// ----------------------------------------------------------------------------
// Transitions are taken one at a time: input ready is high only while idle,
// so a new one waits for the previous write-back, which itself waits for the
// result register to be free. The single table read port walks the row, and
// both multiply steps share one multiplier. Reset: synchronous, active low;
// afterwards the table is cleared one entry a cycle with input ready low;
// configuration writes are taken during the clear.
// ----------------------------------------------------------------------------
module q_table_update_engine import qtue_pkg::*; #(
    parameter int NUM_STATES  = 256,
    parameter int NUM_ACTIONS = 4,
    parameter int Q_WIDTH     = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [STATE_IN_W-1:0]        i_cur_state,
    input  logic [ACT_IN_W-1:0]          i_taken_action,
    input  logic signed [REWARD_W-1:0]   i_reward_value,
    input  logic [STATE_IN_W-1:0]        i_next_state,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [OUT_Q_W-1:0]    o_updated_q,
    output logic signed [OUT_Q_W-1:0]    o_next_max_q,
    output logic [OUT_ACT_W-1:0]         o_greedy_action,
    output logic                         o_saturated
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    qtue_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Table, arithmetic and result register
    qtue_datapath #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS),
        .Q_WIDTH     (Q_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cur_state     (i_cur_state),
        .i_taken_action  (i_taken_action),
        .i_reward_value  (i_reward_value),
        .i_next_state    (i_next_state),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_updated_q     (o_updated_q),
        .o_next_max_q    (o_next_max_q),
        .o_greedy_action (o_greedy_action),
        .o_saturated     (o_saturated)
    );

endmodule
